/* src/vmrs_pkg.sv */
// Shared codes, defaults and types of the valve move/rest sequencer.
package vmrs_pkg;

  // Default sizing.
  localparam int DEF_TABLE_DEPTH   = 16;
  localparam int DEF_DURATION_BITS = 16;

  // Fixed field widths of the channels.
  localparam int OP_W    = 3;
  localparam int IDX_W   = 4;
  localparam int DIR_W   = 2;
  localparam int TICK_W  = 16;
  localparam int MODE_W  = 2;
  localparam int STEPO_W = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_START1 = 3'd1;
  localparam logic [OP_W-1:0] OP_START2 = 3'd2;
  localparam logic [OP_W-1:0] OP_CLOSE  = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd4;

  // Direction and drive codes.
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

  // Run mode codes.
  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;

  // Table write request from the sequencer.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  index;
    logic [DIR_W-1:0]  dir;
    logic [TICK_W-1:0] move;
    logic [TICK_W-1:0] rest;
  } tbl_wr_t;

  // Result beat contents.
  typedef struct packed {
    logic [DIR_W-1:0]   drive;
    logic [MODE_W-1:0]  mode;
    logic [STEPO_W-1:0] step;
    logic               resting;
    logic               armed;
    logic               fired;
  } res_t;

endpackage

/* src/valve_move_rest_sequencer.sv */
// Top level of the valve move/rest sequencer: handshake and result register.
//
// Takes one beat per clock while the result side does not stall and returns
// one result beat for each, held in the execute stage and then the result
// register. The step table sits in a registered-read synchronous RAM that is
// read as the beat is accepted, at the address chosen from the state the
// preceding beat leaves; the execute stage then applies the beat to the timer
// and step registers and loads the result register. Table entries never loaded
// read as zero (direction none) from reset onward, with no clearing pass.
module valve_move_rest_sequencer
  import vmrs_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int DURATION_BITS = DEF_DURATION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [IDX_W-1:0]   in_entry_index,
  input  logic [DIR_W-1:0]   in_entry_direction,
  input  logic [TICK_W-1:0]  in_entry_move_ticks,
  input  logic [TICK_W-1:0]  in_entry_rest_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DIR_W-1:0]   out_motor_drive,
  output logic [MODE_W-1:0]  out_run_mode,
  output logic [STEPO_W-1:0] out_step_number,
  output logic               out_resting,
  output logic               out_timer_armed,
  output logic               out_timer_fired
);

  localparam int AW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;

  logic                     s1_vld_r;
  logic                     out_vld_r;
  res_t                     out_r;
  logic                     exec;
  logic                     acc;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  tbl_wr_t                  wr;
  res_t                     res;
  logic [DIR_W-1:0]         ent_dir;
  logic [DURATION_BITS-1:0] ent_move;
  logic [DURATION_BITS-1:0] ent_rest;

  // Execute when the result register is free or being drained.
  assign exec     = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !exec;
  assign acc      = in_valid && !in_stall;

  vmrs_seq #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .DURATION_BITS (DURATION_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .exec     (exec),
    .in_op    (in_operation),
    .in_index (in_entry_index),
    .in_dir   (in_entry_direction),
    .in_move  (in_entry_move_ticks),
    .in_rest  (in_entry_rest_ticks),
    .ent_dir  (ent_dir),
    .ent_move (ent_move),
    .ent_rest (ent_rest),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .res      (res)
  );

  vmrs_table #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .DURATION_BITS (DURATION_BITS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .ent_dir  (ent_dir),
    .ent_move (ent_move),
    .ent_rest (ent_rest)
  );

  // Track occupancy of the execute stage and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_vld_r <= 1'b1;
      end else if (exec) begin
        s1_vld_r <= 1'b0;
      end
      if (exec) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Hold the result beat until taken.
  always_ff @(posedge clk) begin
    if (exec) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_motor_drive = out_r.drive;
  assign out_run_mode    = out_r.mode;
  assign out_step_number = out_r.step;
  assign out_resting     = out_r.resting;
  assign out_timer_armed = out_r.armed;
  assign out_timer_fired = out_r.fired;

endmodule

/* src/vmrs_ram.sv */
// Generic single-port-write, registered-read RAM.
module vmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/vmrs_table.sv */
// Step table: RAM, per-entry valid bits and write-to-read forwarding.
module vmrs_table
  import vmrs_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int DURATION_BITS = DEF_DURATION_BITS
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           rd_en,
  input  logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
  input  tbl_wr_t                                        wr,
  output logic [DIR_W-1:0]                               ent_dir,
  output logic [DURATION_BITS-1:0]                       ent_move,
  output logic [DURATION_BITS-1:0]                       ent_rest
);

  localparam int AW   = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int EW   = DIR_W + 2 * DURATION_BITS;
  localparam int IDXW = AW > IDX_W ? AW : IDX_W;

  logic [IDXW-1:0]        idx_wide;
  logic [AW-1:0]          waddr;
  logic [EW-1:0]          wdata;
  logic [EW-1:0]          ram_q;
  logic [TABLE_DEPTH-1:0] vld_r;
  logic                   rvld_r;
  logic                   fwd_r;
  logic [EW-1:0]          fwd_data_r;
  logic                   hit;
  logic [EW-1:0]          entry;

  // Pack the write beat, durations kept to the configured width.
  assign idx_wide = IDXW'(wr.index);
  assign waddr    = idx_wide[AW-1:0];
  assign wdata    = {wr.dir, DURATION_BITS'(wr.move), DURATION_BITS'(wr.rest)};
  assign hit      = wr.en && rd_en && (waddr == rd_addr);

  vmrs_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Mark written entries; reset leaves all entries reading as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // Capture validity and forwarding alongside the RAM read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else if (rd_en) begin
      rvld_r <= vld_r[rd_addr];
      fwd_r  <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wdata;
    end
  end

  // Select forwarded, stored or cleared entry.
  always_comb begin
    if (fwd_r) begin
      entry = fwd_data_r;
    end else if (rvld_r) begin
      entry = ram_q;
    end else begin
      entry = '0;
    end
  end

  assign ent_dir  = entry[EW-1 -: DIR_W];
  assign ent_move = entry[2*DURATION_BITS-1 -: DURATION_BITS];
  assign ent_rest = entry[DURATION_BITS-1:0];

endmodule

/* src/vmrs_seq.sv */
// Sequencer: execute stage, timer and step state, table address generation.
module vmrs_seq
  import vmrs_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int DURATION_BITS = DEF_DURATION_BITS
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           acc,
  input  logic                                           exec,
  input  logic [OP_W-1:0]                                in_op,
  input  logic [IDX_W-1:0]                               in_index,
  input  logic [DIR_W-1:0]                               in_dir,
  input  logic [TICK_W-1:0]                              in_move,
  input  logic [TICK_W-1:0]                              in_rest,
  input  logic [DIR_W-1:0]                               ent_dir,
  input  logic [DURATION_BITS-1:0]                       ent_move,
  input  logic [DURATION_BITS-1:0]                       ent_rest,
  output logic                                           rd_en,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
  output tbl_wr_t                                        wr,
  output res_t                                           res
);

  localparam int AW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int DB = DURATION_BITS;

  // Held item in the execute stage.
  logic [OP_W-1:0]   op_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DIR_W-1:0]  dir_r;
  logic [TICK_W-1:0] move_r;
  logic [TICK_W-1:0] rest_r;

  // Sequencer state.
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic              phase_r, phase_nxt;
  logic [DIR_W-1:0]  drive_r, drive_nxt;
  logic [DB-1:0]     ticks_r, ticks_nxt;
  logic              armed_r, armed_nxt;
  logic              fired;

  logic [DB-1:0]     cnt_dec;
  logic [SW-1:0]     step_inc;
  logic              step_in_range;
  logic              inc_in_range;
  logic              dir_go;
  logic [DB-1:0]     move_arm;
  logic [DB-1:0]     rest_arm;

  // Latch the accepted item.
  always_ff @(posedge clk) begin
    if (acc) begin
      op_r   <= in_op;
      idx_r  <= in_index;
      dir_r  <= in_dir;
      move_r <= in_move;
      rest_r <= in_rest;
    end
  end

  assign cnt_dec       = ticks_r - 1'b1;
  assign step_inc      = step_r + 1'b1;
  assign step_in_range = 32'(step_r) < 32'(TABLE_DEPTH);
  assign inc_in_range  = 32'(step_inc) < 32'(TABLE_DEPTH);
  assign dir_go        = (ent_dir == DIR_CW) || (ent_dir == DIR_CCW);
  assign move_arm      = (ent_move == '0) ? DB'(1) : ent_move;
  assign rest_arm      = (ent_rest == '0) ? DB'(1) : ent_rest;

  // Apply the held item to the state.
  always_comb begin
    mode_nxt  = mode_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    drive_nxt = drive_r;
    ticks_nxt = ticks_r;
    armed_nxt = armed_r;
    fired     = 1'b0;
    wr.en     = 1'b0;
    wr.index  = idx_r;
    wr.dir    = dir_r;
    wr.move   = move_r;
    wr.rest   = rest_r;
    if (exec) begin
      case (op_r)
        OP_TICK: begin
          if (armed_r) begin
            ticks_nxt = cnt_dec;
            if (cnt_dec == '0) begin
              armed_nxt = 1'b0;
              fired     = 1'b1;
              if (mode_r != MODE_IDLE) begin
                if (!phase_r) begin
                  // End of move: stop and rest.
                  drive_nxt = DIR_NONE;
                  phase_nxt = 1'b1;
                  if (step_in_range) begin
                    armed_nxt = 1'b1;
                    ticks_nxt = rest_arm;
                  end
                end else if (step_in_range) begin
                  // End of rest: advance and, if the next entry is in range with a direction, start its move.
                  step_nxt = step_inc;
                  if (inc_in_range && dir_go) begin
                    drive_nxt = ent_dir;
                    armed_nxt = 1'b1;
                    ticks_nxt = move_arm;
                    phase_nxt = 1'b0;
                  end
                end
              end
            end
          end
        end
        OP_START1, OP_START2: begin
          if (mode_r == MODE_IDLE) begin
            mode_nxt  = MODE_W'(op_r);
            step_nxt  = '0;
            phase_nxt = 1'b0;
            if (dir_go) begin
              drive_nxt = ent_dir;
              armed_nxt = 1'b1;
              ticks_nxt = move_arm;
            end
          end
        end
        OP_CLOSE: begin
          armed_nxt = 1'b0;
          mode_nxt  = MODE_IDLE;
        end
        OP_LOAD: begin
          wr.en = (mode_r == MODE_IDLE) && (32'(idx_r) < 32'(TABLE_DEPTH));
        end
        default: begin
        end
      endcase
    end
  end

  // Advance state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      step_r  <= '0;
      phase_r <= 1'b0;
      drive_r <= DIR_NONE;
      ticks_r <= '0;
      armed_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      drive_r <= drive_nxt;
      ticks_r <= ticks_nxt;
      armed_r <= armed_nxt;
    end
  end

  // Fetch the entry the incoming item may need, against the state it will see.
  assign rd_en = acc;
  always_comb begin
    case (in_op)
      OP_START1, OP_START2: rd_addr = '0;
      OP_TICK: begin
        if (phase_nxt) begin
          rd_addr = AW'(step_nxt + 1'b1);
        end else begin
          rd_addr = AW'(step_nxt);
        end
      end
      default: rd_addr = AW'(step_nxt);
    endcase
  end

  // Result beat shows the state after the item.
  assign res.drive   = drive_nxt;
  assign res.mode    = mode_nxt;
  assign res.step    = STEPO_W'(step_nxt);
  assign res.resting = phase_nxt;
  assign res.armed   = armed_nxt;
  assign res.fired   = fired;

endmodule
